FILE: src/lj_pkg.sv
// ----------------------------------------------------------------------------
// lj_pkg: shared types and constants
// Field widths, register reset values, register indexes and the pipeline
// side-band record for the Lennard-Jones pair force pipeline.
// ----------------------------------------------------------------------------
package lj_pkg;

   localparam int COORD_FRAC_BITS_DEF = 20;
   localparam int COORD_W             = 32;
   localparam int FORCE_W             = 48;
   localparam int CUTOFF_W            = 32;
   localparam int STRENGTH_W          = 24;
   localparam int STRENGTH_FRAC       = 16;
   localparam int FORCE_SHIFT_BASE    = 8;
   localparam int RECIP_BITS          = 64;
   localparam int MUL_LAT             = 3;
   localparam int CSR_DATA_W          = 32;

   localparam logic [CUTOFF_W-1:0]   CUTOFF_RESET   = 32'd9437184;
   localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 24'd655360;

   typedef enum logic [0:0] {
      CSR_CUTOFF_SQ = 1'b0,
      CSR_STRENGTH  = 1'b1
   } csr_idx_type;

   // Per-item record that travels beside the arithmetic
   typedef struct packed {
      logic                        vld;
      logic                        in_range;
      logic                        tiny;
      logic [2:0]                  neg;
      logic [2:0][COORD_W-1:0]     mag;
   } side_type;

endpackage

FILE: src/lj_req_if.sv
// ----------------------------------------------------------------------------
// lj_req_if: pair displacement channel
// Valid/ready channel carrying one displacement vector per beat.
// ----------------------------------------------------------------------------
interface lj_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [lj_pkg::COORD_W-1:0]     dx;
   logic signed [lj_pkg::COORD_W-1:0]     dy;
   logic signed [lj_pkg::COORD_W-1:0]     dz;

   modport source (output valid, dx, dy, dz, input ready);
   modport sink   (input valid, dx, dy, dz, output ready);
endinterface

FILE: src/lj_rsp_if.sv
// ----------------------------------------------------------------------------
// lj_rsp_if: pair force channel
// Valid/ready channel carrying one force vector and its flags per beat.
// ----------------------------------------------------------------------------
interface lj_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [lj_pkg::FORCE_W-1:0]     fx;
   logic signed [lj_pkg::FORCE_W-1:0]     fy;
   logic signed [lj_pkg::FORCE_W-1:0]     fz;
   logic                                  within_cutoff;
   logic                                  saturated;

   modport source (output valid, fx, fy, fz, within_cutoff, saturated, input ready);
   modport sink   (input valid, fx, fy, fz, within_cutoff, saturated, output ready);
endinterface

FILE: src/lj_dly.sv
// ----------------------------------------------------------------------------
// lj_dly: enabled delay line
// Carries side-band data alongside the arithmetic stages.
// ----------------------------------------------------------------------------
module lj_dly #(
   parameter int W = 1,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] pipe_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) pipe_ff[i] <= '0;
      end else if (en) begin
         pipe_ff[0] <= d;
         for (int i = 1; i < N; i++) pipe_ff[i] <= pipe_ff[i-1];
      end
   end

   assign q = pipe_ff[N-1];

endmodule

FILE: src/lj_mul.sv
// ----------------------------------------------------------------------------
// lj_mul: 64x64 multiplier with right shift and overflow detect
// Three stages: partial products, middle sum, final add and select.
// ----------------------------------------------------------------------------
module lj_mul #(
   parameter int SHIFT = 32
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p,
   output logic        ovf
);

   logic [63:0]  pp0_ff, pp1_ff, pp2_ff, pp3_ff;
   logic [64:0]  mid_ff;
   logic [63:0]  lo_ff, hi_ff;
   logic [127:0] full;
   logic [63:0]  p_ff;
   logic         ovf_ff;

   assign full = {hi_ff, lo_ff} + (128'(mid_ff) << 32);

   always_ff @(posedge clock) begin
      if (en) begin
         pp0_ff <= a[31:0]  * b[31:0];
         pp1_ff <= a[31:0]  * b[63:32];
         pp2_ff <= a[63:32] * b[31:0];
         pp3_ff <= a[63:32] * b[63:32];
         mid_ff <= 65'(pp1_ff) + 65'(pp2_ff);
         lo_ff  <= pp0_ff;
         hi_ff  <= pp3_ff;
         p_ff   <= full[SHIFT+63:SHIFT];
         ovf_ff <= |full[127:SHIFT+64];
      end
   end

   assign p   = p_ff;
   assign ovf = ovf_ff;

endmodule

FILE: src/lj_recip.sv
// ----------------------------------------------------------------------------
// lj_recip: pipelined reciprocal
// floor(2^64 / rq) for rq >= 2, one restoring division bit per stage.
// ----------------------------------------------------------------------------
module lj_recip (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rq,
   output logic [63:0] u
);

   localparam int NB = lj_pkg::RECIP_BITS;

   logic [63:0] rem_ff [NB];
   logic [63:0] rq_ff  [NB];
   logic [63:0] q_ff   [NB];

   for (genvar j = 0; j < NB; j++) begin : g_stage
      logic [63:0] rem_prev, rq_prev, q_prev;
      logic [64:0] trial;
      logic        take;

      if (j == 0) begin : g_first
         assign rem_prev = 64'd1;
         assign rq_prev  = rq;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign rq_prev  = rq_ff[j-1];
         assign q_prev   = q_ff[j-1];
      end

      assign trial = {rem_prev, 1'b0};
      assign take  = trial >= {1'b0, rq_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= take ? 64'(trial - {1'b0, rq_prev}) : trial[63:0];
            rq_ff[j]  <= rq_prev;
            q_ff[j]   <= {q_prev[62:0], take};
         end
      end
   end

   assign u = q_ff[NB-1];

endmodule

FILE: src/lennard_jones_pair_force_top.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_top: Lennard-Jones pair force with cutoff
// Fixed-point force pipeline taking one displacement beat per cycle while rsp_chan is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one displacement (dx, dy, dz) per beat; rsp_chan returns
//   exactly one force beat (fx, fy, fz, within_cutoff, saturated) for each,
//   in order. Both are valid/ready; a beat moves when valid and ready are high.
//   csr_* writes cutoff_sq (index 0) or strength (index 1); write only while
//   the pipeline is empty.
//   Throughput: one beat per cycle while rsp_chan is not stalled. The pipeline
//   is made up mainly of the 64-stage restoring reciprocal (one quotient bit
//   per stage) and five three-stage 64x64 multiplier ranks built from 32x32
//   partial products.
//   Reset clears all valid bits and loads cutoff_sq 9.0 and strength 10.0.
//   When the receiver stalls, the whole pipeline freezes: req_chan.ready drops
//   while a result waits in the output register, and nothing is lost or
//   repeated.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_top #(
   parameter int COORD_FRAC_BITS = lj_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   lj_req_if.sink                          req_chan,
   lj_rsp_if.source                        rsp_chan,
   input  logic                            csr_wr_en,
   input  lj_pkg::csr_idx_type             csr_index,
   input  logic [lj_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int FSH = lj_pkg::FORCE_SHIFT_BASE + COORD_FRAC_BITS;

   // Configuration registers
   logic [lj_pkg::CUTOFF_W-1:0]   cutoff_sq_ff;
   logic [lj_pkg::STRENGTH_W-1:0] strength_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_sq_ff <= lj_pkg::CUTOFF_RESET;
         strength_ff  <= lj_pkg::STRENGTH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lj_pkg::CSR_CUTOFF_SQ: cutoff_sq_ff <= csr_wdata[lj_pkg::CUTOFF_W-1:0];
            lj_pkg::CSR_STRENGTH:  strength_ff  <= csr_wdata[lj_pkg::STRENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Global advance: the pipeline moves whenever the output register is empty or being read
   logic adv;
   logic rsp_vld_ff;

   assign adv            = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Stage A: magnitudes and signs
   logic [31:0]      in_d [3];
   lj_pkg::side_type a_side_ff, a_side_in;

   assign in_d[0] = req_chan.dx;
   assign in_d[1] = req_chan.dy;
   assign in_d[2] = req_chan.dz;

   always_comb begin
      a_side_in        = '0;
      a_side_in.vld    = req_chan.valid;
      for (int i = 0; i < 3; i++) begin
         a_side_in.neg[i] = in_d[i][31];
         a_side_in.mag[i] = in_d[i][31] ? (~in_d[i] + 32'd1) : in_d[i];
      end
   end

   // Stage B: squares
   lj_pkg::side_type b_side_ff;
   logic [63:0]      b_sq_ff [3];

   // Stage C: sum, cutoff test, Q32.32 distance
   lj_pkg::side_type c_side_ff, c_side_in;
   logic [63:0]      c_rq_ff, c_rq_in;
   logic [63:0]      sum;
   logic [95:0]      sum_wide;
   logic [63:0]      cut_ext;

   assign sum      = b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
   assign cut_ext  = 64'(cutoff_sq_ff) << COORD_FRAC_BITS;
   assign sum_wide = {sum, 32'd0} >> (2 * COORD_FRAC_BITS);

   always_comb begin
      c_side_in          = b_side_ff;
      c_side_in.in_range = sum <= cut_ext;
      c_side_in.tiny     = sum_wide[63:0] <= 64'd1;
      // keep the divisor legal; the tiny flag overrides the quotient
      c_rq_in            = c_side_in.tiny ? 64'd2 : sum_wide[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_side_ff      <= '0;
         b_side_ff      <= '0;
         c_side_ff      <= '0;
      end else if (adv) begin
         a_side_ff      <= a_side_in;
         b_side_ff      <= a_side_ff;
         c_side_ff      <= c_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) b_sq_ff[i] <= a_side_ff.mag[i] * a_side_ff.mag[i];
         c_rq_ff <= c_rq_in;
      end
   end

   // Reciprocal u = 1/R in Q32.32
   logic [63:0]      e_u;
   lj_pkg::side_type e_side;

   lj_recip u_recip (.clock(clock), .en(adv), .rq(c_rq_ff), .u(e_u));

   lj_dly #(.W($bits(lj_pkg::side_type)), .N(lj_pkg::RECIP_BITS)) u_dly_e (
      .clock(clock), .reset(reset), .en(adv), .d(c_side_ff), .q(e_side));

   // u^2
   logic [63:0]      f_u2, f_u;
   logic             f_ov;
   lj_pkg::side_type f_side;

   lj_mul #(.SHIFT(32)) u_mul_u2 (
      .clock(clock), .en(adv), .a(e_u), .b(e_u), .p(f_u2), .ovf(f_ov));
   lj_dly #(.W(64), .N(lj_pkg::MUL_LAT)) u_dly_fu (
      .clock(clock), .reset(reset), .en(adv), .d(e_u), .q(f_u));
   lj_dly #(.W($bits(lj_pkg::side_type)), .N(lj_pkg::MUL_LAT)) u_dly_f (
      .clock(clock), .reset(reset), .en(adv), .d(e_side), .q(f_side));

   // u^4 and u^3 side by side
   logic [63:0]      g_u4, g_u3;
   logic             g_ov4, g_ov3, g_ov2;
   lj_pkg::side_type g_side;

   lj_mul #(.SHIFT(32)) u_mul_u4 (
      .clock(clock), .en(adv), .a(f_u2), .b(f_u2), .p(g_u4), .ovf(g_ov4));
   lj_mul #(.SHIFT(32)) u_mul_u3 (
      .clock(clock), .en(adv), .a(f_u2), .b(f_u), .p(g_u3), .ovf(g_ov3));
   lj_dly #(.W(1), .N(lj_pkg::MUL_LAT)) u_dly_gov (
      .clock(clock), .reset(reset), .en(adv), .d(f_ov), .q(g_ov2));
   lj_dly #(.W($bits(lj_pkg::side_type)), .N(lj_pkg::MUL_LAT)) u_dly_g (
      .clock(clock), .reset(reset), .en(adv), .d(f_side), .q(g_side));

   // u^7
   logic [63:0]      h_u7, h_u4;
   logic             h_ov7, h_ovp;
   lj_pkg::side_type h_side;

   lj_mul #(.SHIFT(32)) u_mul_u7 (
      .clock(clock), .en(adv), .a(g_u4), .b(g_u3), .p(h_u7), .ovf(h_ov7));
   lj_dly #(.W(65), .N(lj_pkg::MUL_LAT)) u_dly_hu4 (
      .clock(clock), .reset(reset), .en(adv),
      .d({g_u4, g_ov2 | g_ov3 | g_ov4}), .q({h_u4, h_ovp}));
   lj_dly #(.W($bits(lj_pkg::side_type)), .N(lj_pkg::MUL_LAT)) u_dly_h (
      .clock(clock), .reset(reset), .en(adv), .d(g_side), .q(h_side));

   // Stage D: difference u^7 - u^4 as sign and magnitude
   lj_pkg::side_type d_side_ff;
   logic [63:0]      d_mag_ff;
   logic             d_gneg_ff, d_infp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_side_ff <= '0;
      end else if (adv) begin
         d_side_ff <= h_side;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_gneg_ff <= h_u7 < h_u4;
         d_mag_ff  <= (h_u7 >= h_u4) ? (h_u7 - h_u4) : (h_u4 - h_u7);
         d_infp_ff <= h_side.tiny || h_ovp || h_ov7;
      end
   end

   // Scalar k = strength * |d| >> 16
   logic [63:0]      k_val;
   logic             k_ovf, k_gneg, k_infp;
   lj_pkg::side_type k_side;

   lj_mul #(.SHIFT(lj_pkg::STRENGTH_FRAC)) u_mul_k (
      .clock(clock), .en(adv), .a(64'(strength_ff)), .b(d_mag_ff),
      .p(k_val), .ovf(k_ovf));
   lj_dly #(.W(2), .N(lj_pkg::MUL_LAT)) u_dly_kf (
      .clock(clock), .reset(reset), .en(adv),
      .d({d_gneg_ff, d_infp_ff}), .q({k_gneg, k_infp}));
   lj_dly #(.W($bits(lj_pkg::side_type)), .N(lj_pkg::MUL_LAT)) u_dly_k (
      .clock(clock), .reset(reset), .en(adv), .d(d_side_ff), .q(k_side));

   // Components |f| = k * |v| >> (8 + frac); the sign of d counts only when
   // the powers were finite
   logic [63:0]      m_f [3];
   logic [2:0]       m_ovf;
   logic             m_gneg, m_inf;
   lj_pkg::side_type m_side;

   for (genvar i = 0; i < 3; i++) begin : g_comp
      lj_mul #(.SHIFT(FSH)) u_mul_f (
         .clock(clock), .en(adv), .a(k_val), .b(64'(k_side.mag[i])),
         .p(m_f[i]), .ovf(m_ovf[i]));
   end

   lj_dly #(.W(2), .N(lj_pkg::MUL_LAT)) u_dly_mf (
      .clock(clock), .reset(reset), .en(adv),
      .d({k_gneg && !k_infp, k_infp || k_ovf}), .q({m_gneg, m_inf}));
   lj_dly #(.W($bits(lj_pkg::side_type)), .N(lj_pkg::MUL_LAT)) u_dly_m (
      .clock(clock), .reset(reset), .en(adv), .d(k_side), .q(m_side));

   // Output stage: clamp, sign, drop the force beyond the cutoff
   logic [lj_pkg::FORCE_W-1:0] o_f_in [3];
   logic                       o_sat_in;
   logic [lj_pkg::FORCE_W-1:0] o_f_ff [3];
   logic                       o_within_ff, o_sat_ff;

   always_comb begin
      logic [63:0] lim;
      logic [63:0] fm;
      logic        fneg;
      lim      = '0;
      fm       = '0;
      fneg     = 1'b0;
      o_sat_in = m_inf;
      for (int i = 0; i < 3; i++) begin
         fneg = m_gneg ^ m_side.neg[i];
         lim  = fneg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
         if (m_side.mag[i] == '0) begin
            fm = '0;
         end else if (m_inf) begin
            fm = lim;
         end else if (m_ovf[i] || m_f[i] > lim) begin
            fm       = lim;
            o_sat_in = 1'b1;
         end else begin
            fm = m_f[i];
         end
         o_f_in[i] = fneg ? (~fm[lj_pkg::FORCE_W-1:0] + 48'd1) : fm[lj_pkg::FORCE_W-1:0];
         if (!m_side.in_range) o_f_in[i] = '0;
      end
      if (!m_side.in_range) o_sat_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= m_side.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) o_f_ff[i] <= o_f_in[i];
         o_within_ff <= m_side.in_range;
         o_sat_ff    <= o_sat_in;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.fx            = o_f_ff[0];
   assign rsp_chan.fy            = o_f_ff[1];
   assign rsp_chan.fz            = o_f_ff[2];
   assign rsp_chan.within_cutoff = o_within_ff;
   assign rsp_chan.saturated     = o_sat_ff;

   // Checks
   a_far_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.within_cutoff |->
         rsp_chan.fx == '0 && rsp_chan.fy == '0 && rsp_chan.fz == '0 &&
         !rsp_chan.saturated)
      else $error("force beyond cutoff is not zero");

   a_inf_flags: assert property (@(posedge clock) disable iff (reset)
      adv && m_side.vld && m_side.in_range && m_inf |=> rsp_chan.saturated)
      else $error("infinite scalar did not raise saturated");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid straight after reset");

endmodule
